[rtl/pfnsb_pkg.sv]
package pfnsb_pkg;

    // Signed Q.16 channel value, range -8.0 .. +8.0
    localparam int QW = 21;
    typedef logic signed [QW-1:0] t_q16;
    typedef logic [3:0][QW-1:0] t_q16_vec;

    localparam logic [QW-1:0] ONE_Q16 = 21'sd65536;
    localparam logic [QW-1:0] SAT_Q16 = 21'sd524288;

    localparam logic [3:0] FMT_UNORM8   = 4'd0;
    localparam logic [3:0] FMT_SNORM8   = 4'd1;
    localparam logic [3:0] FMT_UNORM16  = 4'd2;
    localparam logic [3:0] FMT_SNORM16  = 4'd3;
    localparam logic [3:0] FMT_UNORM32  = 4'd4;
    localparam logic [3:0] FMT_SNORM32  = 4'd5;
    localparam logic [3:0] FMT_FLOAT32  = 4'd6;
    localparam logic [3:0] FMT_4444     = 4'd7;
    localparam logic [3:0] FMT_5551     = 4'd8;
    localparam logic [3:0] FMT_2101010  = 4'd9;
    localparam logic [3:0] FMT_565      = 4'd10;
    localparam logic [3:0] FMT_24_8     = 4'd11;
    localparam logic [3:0] FMT_F32_24_8 = 4'd12;
    localparam logic [3:0] FMT_332      = 4'd13;

    localparam logic [2:0] CFG_FORMAT     = 3'd0;
    localparam logic [2:0] CFG_COUNT      = 3'd1;
    localparam logic [2:0] CFG_ROUTING    = 3'd2;
    localparam logic [2:0] CFG_SCALE_LO   = 3'd3;
    localparam logic [2:0] CFG_SCALE_HI   = 3'd4;
    localparam logic [2:0] CFG_BIAS_LO    = 3'd5;
    localparam logic [2:0] CFG_BIAS_HI    = 3'd6;

    typedef struct packed {
        logic [3:0]  format_code;
        logic [2:0]  component_count;
        logic [11:0] channel_routing;
        logic [31:0] scale_lo;
        logic [31:0] scale_hi;
        logic [31:0] bias_lo;
        logic [31:0] bias_hi;
    } t_cfg;

    // x * 65536 / (2^k - 1), rounded; 16 = k*m + r0. Constant k folds to shifts and adds.
    function automatic t_q16 f_unorm_m1(input logic [16:0] x, input int k, input int m,
                                        input int r0);
        logic [31:0] s_sum;
        logic [31:0] xs;
        logic [31:0] z;
        logic [31:0] zh;
        logic [31:0] zl;
        logic [31:0] w;
        logic [31:0] d;
        logic [31:0] y;
        logic [31:0] q;
        s_sum = '0;
        for (int j = 0; j < 8; j++) begin
            if (j < m) s_sum = s_sum | (32'd1 << (j * k));
        end
        d  = (32'd1 << k) - 32'd1;
        xs = {15'd0, x} << r0;
        z  = xs + ((32'd1 << (k - 1)) - 32'd1);
        zh = z >> k;
        zl = z & d;
        w  = zh + zl;
        y  = zh;
        if (w >= (d << 1)) y = zh + 32'd2;
        else if (w >= d) y = zh + 32'd1;
        q = (xs * s_sum) + y;
        return q[QW-1:0];
    endfunction

    function automatic t_q16 f_snorm_fin(input t_q16 mag, input logic neg);
        t_q16 q;
        q = neg ? -mag : mag;
        if (q < -$signed(ONE_Q16)) q = -$signed(ONE_Q16);
        return q;
    endfunction

    function automatic t_q16 f_unorm32(input logic [31:0] x);
        logic [32:0] s;
        logic [16:0] q;
        s = {17'd0, x[31:16]} + {1'b0, x[15:0], 16'd0};
        q = {1'b0, x[31:16]} + {16'd0, (s >= 33'h0_8000_0000)};
        return {4'd0, q};
    endfunction

    function automatic t_q16 f_unorm24(input logic [23:0] x);
        logic [24:0] s;
        logic [16:0] q;
        s = {9'd0, x[23:8]} + {1'b0, x[7:0], 16'd0};
        q = {1'b0, x[23:8]} + {16'd0, (s >= 25'h080_0000)};
        return {4'd0, q};
    endfunction

    // Magnitude up to 2^31 over 2^31 - 1
    function automatic t_q16 f_snorm32_mag(input logic [31:0] x);
        logic [32:0] s;
        logic [17:0] q;
        s = {16'd0, x[31:15]} + {2'b0, x[14:0], 16'd0};
        q = {1'b0, x[31:15]} + {17'd0, (s >= 33'h0_4000_0000)};
        return {3'd0, q};
    endfunction

    function automatic t_q16 f_float_q16(input logic [31:0] x);
        logic [7:0]  e;
        logic [7:0]  sh;
        logic [24:0] mm;
        logic [24:0] rnd;
        t_q16 mag;
        e   = x[30:23];
        sh  = 8'd134 - e;
        mm  = {2'b01, x[22:0]};
        rnd = '0;
        mag = '0;
        if (e == 8'hff && x[22:0] != 23'd0) begin
            mag = '0;
        end else if (e >= 8'd130) begin
            mag = SAT_Q16;
        end else if (e == 8'd0) begin
            mag = '0;
        end else if (sh >= 8'd25) begin
            mag = '0;
        end else begin
            rnd = (mm + (25'd1 << (sh - 8'd1))) >> sh;
            mag = (rnd > 25'(SAT_Q16)) ? SAT_Q16 : rnd[QW-1:0];
        end
        return x[31] ? -mag : mag;
    endfunction

endpackage

[rtl/pfnsb_front.sv]
module pfnsb_front
    import pfnsb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_word [4],
    output logic        o_valid,
    input  logic        i_ready,
    output t_q16_vec    o_vals
);

    logic     r_valid;
    t_q16_vec r_vals;
    t_q16_vec n_vals;
    logic     adv;
    logic [31:0] p;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_valid;
    assign o_vals  = r_vals;
    assign p       = i_word[0];

    always_comb begin
        n_vals[0] = '0;
        n_vals[1] = '0;
        n_vals[2] = '0;
        n_vals[3] = ONE_Q16;
        if (i_cfg.format_code <= FMT_FLOAT32) begin
            for (int c = 0; c < 4; c++) begin
                if (c == 0 || 3'(c) < i_cfg.component_count) begin
                    unique case (i_cfg.format_code)
                        FMT_UNORM8:  n_vals[c] = f_unorm_m1({9'd0, i_word[c][7:0]}, 8, 2, 0);
                        FMT_SNORM8:  n_vals[c] = f_snorm_fin(f_unorm_m1(
                            {9'd0, i_word[c][7] ? 8'(-i_word[c][7:0]) : i_word[c][7:0]},
                            7, 2, 2), i_word[c][7]);
                        FMT_UNORM16: n_vals[c] = f_unorm_m1({1'b0, i_word[c][15:0]}, 16, 1, 0);
                        FMT_SNORM16: n_vals[c] = f_snorm_fin(f_unorm_m1(
                            {1'b0, i_word[c][15] ? 16'(-i_word[c][15:0]) : i_word[c][15:0]},
                            15, 1, 1), i_word[c][15]);
                        FMT_UNORM32: n_vals[c] = f_unorm32(i_word[c]);
                        FMT_SNORM32: n_vals[c] = f_snorm_fin(f_snorm32_mag(
                            i_word[c][31] ? 32'(-i_word[c]) : i_word[c]), i_word[c][31]);
                        default:     n_vals[c] = f_float_q16(i_word[c]);
                    endcase
                end
            end
        end else begin
            unique case (i_cfg.format_code)
                FMT_4444: begin
                    n_vals[3] = f_unorm_m1({13'd0, p[3:0]}, 4, 4, 0);
                    n_vals[2] = f_unorm_m1({13'd0, p[7:4]}, 4, 4, 0);
                    n_vals[1] = f_unorm_m1({13'd0, p[11:8]}, 4, 4, 0);
                    n_vals[0] = f_unorm_m1({13'd0, p[15:12]}, 4, 4, 0);
                end
                FMT_5551: begin
                    n_vals[3] = p[0] ? ONE_Q16 : '0;
                    n_vals[2] = f_unorm_m1({12'd0, p[5:1]}, 5, 3, 1);
                    n_vals[1] = f_unorm_m1({12'd0, p[10:6]}, 5, 3, 1);
                    n_vals[0] = f_unorm_m1({12'd0, p[15:11]}, 5, 3, 1);
                end
                FMT_2101010: begin
                    n_vals[0] = f_unorm_m1({7'd0, p[9:0]}, 10, 1, 6);
                    n_vals[1] = f_unorm_m1({7'd0, p[19:10]}, 10, 1, 6);
                    n_vals[2] = f_unorm_m1({7'd0, p[29:20]}, 10, 1, 6);
                    n_vals[3] = f_unorm_m1({15'd0, p[31:30]}, 2, 8, 0);
                end
                FMT_565: begin
                    n_vals[2] = f_unorm_m1({12'd0, p[4:0]}, 5, 3, 1);
                    n_vals[1] = f_unorm_m1({11'd0, p[10:5]}, 6, 2, 4);
                    n_vals[0] = f_unorm_m1({12'd0, p[15:11]}, 5, 3, 1);
                end
                FMT_24_8: begin
                    n_vals[1] = f_unorm_m1({9'd0, p[7:0]}, 8, 2, 0);
                    n_vals[0] = f_unorm24(p[31:8]);
                end
                FMT_F32_24_8: begin
                    n_vals[1] = f_unorm_m1({9'd0, i_word[1][7:0]}, 8, 2, 0);
                    n_vals[0] = f_float_q16(p);
                end
                FMT_332: begin
                    n_vals[2] = f_unorm_m1({15'd0, p[1:0]}, 2, 8, 0);
                    n_vals[1] = f_unorm_m1({14'd0, p[4:2]}, 3, 5, 1);
                    n_vals[0] = f_unorm_m1({14'd0, p[7:5]}, 3, 5, 1);
                end
                // unused codes keep the defaults
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
        if (adv && i_valid) begin
            r_vals <= n_vals;
        end
    end

endmodule

[rtl/pfnsb_queue.sv]
module pfnsb_queue
    import pfnsb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push_valid,
    output logic     o_push_ready,
    input  t_q16_vec i_push_data,
    output logic     o_pop_valid,
    input  logic     i_pop_ready,
    output t_q16_vec o_pop_data
);

    t_q16_vec   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= !r_wr_ptr;
            if (pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[rtl/pfnsb_back.sv]
module pfnsb_back
    import pfnsb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_q16_vec   i_vals,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_bytes [4],
    output logic [3:0] o_mask
);

    logic               r_s1_valid;
    logic signed [36:0] r_prod [4];
    logic [3:0]         r_hit;
    logic signed [36:0] n_prod [4];
    logic [3:0]         n_hit;
    logic               r_o_valid;
    logic [7:0]         r_bytes [4];
    logic [3:0]         r_mask;
    logic [7:0]         n_bytes [4];
    logic               s2_adv;
    logic               s1_adv;

    assign s2_adv  = !r_o_valid || i_ready;
    assign s1_adv  = !r_s1_valid || s2_adv;
    assign o_ready = s1_adv;
    assign o_valid = r_o_valid;
    assign o_bytes = r_bytes;
    assign o_mask  = r_mask;

    // Route: the highest enabled channel targeting a slot wins; multiply by the slot scale
    always_comb begin
        logic [31:0]        sreg;
        logic signed [15:0] scale;
        t_q16               v;
        for (int s = 0; s < 4; s++) begin
            v        = '0;
            n_hit[s] = 1'b0;
            for (int c = 0; c < 4; c++) begin
                if (i_cfg.channel_routing[3*c+2] && i_cfg.channel_routing[3*c +: 2] == 2'(s)) begin
                    v        = $signed(i_vals[c]);
                    n_hit[s] = 1'b1;
                end
            end
            sreg      = (s < 2) ? i_cfg.scale_lo : i_cfg.scale_hi;
            scale     = $signed(s[0] ? sreg[31:16] : sreg[15:0]);
            n_prod[s] = 37'(v) * 37'(scale);
        end
    end

    // Add bias, clamp to 0..1, scale to 0..255 and truncate
    always_comb begin
        logic [31:0]        breg;
        logic signed [15:0] bias;
        logic signed [37:0] sum;
        logic [35:0]        x255;
        for (int s = 0; s < 4; s++) begin
            breg = (s < 2) ? i_cfg.bias_lo : i_cfg.bias_hi;
            bias = $signed(s[0] ? breg[31:16] : breg[15:0]);
            sum  = 38'(r_prod[s]) + (38'(bias) <<< 16);
            x255 = {sum[27:0], 8'd0} - {8'd0, sum[27:0]};
            if (!r_hit[s] || sum <= 38'sd0) begin
                n_bytes[s] = 8'd0;
            end else if (sum >= 38'sd268435456) begin
                n_bytes[s] = 8'd255;
            end else begin
                n_bytes[s] = x255[35:28];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_adv) r_s1_valid <= i_valid;
            if (s2_adv) r_o_valid  <= r_s1_valid;
        end
        if (s1_adv && i_valid) begin
            r_prod <= n_prod;
            r_hit  <= n_hit;
        end
        if (s2_adv && r_s1_valid) begin
            r_bytes <= n_bytes;
            r_mask  <= r_hit;
        end
    end

endmodule

[rtl/pixel_format_normalize_scale_bias.sv]
// Pixel unpack to four destination bytes with per-byte scale and bias.
//
// Input stream: one transaction carries one source pixel as four 32-bit
// words; the words are decoded by the format register into four normalized
// channels, routed to byte slots, scaled, biased, clamped and quantized.
// Output stream: one transaction per input with four bytes and a write mask.
// Configuration: write enable, register index and data; write only while
// the block is idle.
//
// Pipeline: the front decode register loads at input acceptance, followed
// in order by the queue, the multiply stage and the output register.
// Throughput: one pixel per clock; every stage advances each clock while
// the receiver is ready.
// Reset clears all valid flags and loads the register defaults. When the
// receiver stalls, the back pipeline holds; the two-entry queue absorbs the
// front, and input ready drops once the queue and the front register fill.
module pixel_format_normalize_scale_bias
    import pfnsb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // word_zero[31:0], word_one[63:32], word_two[95:64], word_three[127:96]
    input  logic [127:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // byte_zero[7:0], byte_one[15:8], byte_two[23:16], byte_three[31:24],
    // byte_write_mask[35:32], zero pad [39:36]
    output logic [39:0]  o_m_axis_tdata
);

    t_cfg        r_cfg;
    logic [31:0] words [4];
    logic        f_valid;
    logic        f_ready;
    t_q16_vec    f_vals;
    logic        q_valid;
    logic        q_ready;
    t_q16_vec    q_vals;
    logic [7:0]  out_bytes [4];
    logic [3:0]  out_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.format_code     <= FMT_UNORM8;
            r_cfg.component_count <= 3'd4;
            r_cfg.channel_routing <= 12'd4012;
            r_cfg.scale_lo        <= 32'h1000_1000;
            r_cfg.scale_hi        <= 32'h1000_1000;
            r_cfg.bias_lo         <= 32'd0;
            r_cfg.bias_hi         <= 32'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FORMAT:   r_cfg.format_code     <= i_cfg_wdata[3:0];
                CFG_COUNT:    r_cfg.component_count <= i_cfg_wdata[2:0];
                CFG_ROUTING:  r_cfg.channel_routing <= i_cfg_wdata[11:0];
                CFG_SCALE_LO: r_cfg.scale_lo        <= i_cfg_wdata;
                CFG_SCALE_HI: r_cfg.scale_hi        <= i_cfg_wdata;
                CFG_BIAS_LO:  r_cfg.bias_lo         <= i_cfg_wdata;
                CFG_BIAS_HI:  r_cfg.bias_hi         <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign words[0] = i_s_axis_tdata[31:0];
    assign words[1] = i_s_axis_tdata[63:32];
    assign words[2] = i_s_axis_tdata[95:64];
    assign words[3] = i_s_axis_tdata[127:96];

    pfnsb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_word  (words),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_vals  (f_vals)
    );

    pfnsb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_vals),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_vals)
    );

    pfnsb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_vals  (q_vals),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_bytes (out_bytes),
        .o_mask  (out_mask)
    );

    assign o_m_axis_tdata = {4'd0, out_mask, out_bytes[3], out_bytes[2],
                             out_bytes[1], out_bytes[0]};

endmodule

[bench/pfnsb_checker.sv]
module pfnsb_checker
    import pfnsb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [39:0]  i_m_tdata,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] wmask;
        logic [7:0] b3;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
    } t_pixel_out;

    logic [3:0]  fmt;
    logic [2:0]  ncomp;
    logic [11:0] route;
    logic [31:0] scl_lo, scl_hi, bia_lo, bia_hi;
    t_pixel_out  expected_pixels[$];

    function automatic longint norm_u(longint unsigned x, longint unsigned d);
        return longint'((x * 65536 + d / 2) / d);
    endfunction

    function automatic longint norm_s(longint x, longint unsigned d);
        longint unsigned mag;
        longint q;
        mag = (x < 0) ? longint'(-x) : longint'(x);
        q = longint'((mag * 65536 + d / 2) / d);
        if (x < 0) q = -q;
        if (q < -65536) q = -65536;
        return q;
    endfunction

    function automatic longint flt_to_q16(logic [31:0] f);
        longint unsigned e, m, s;
        longint mag;
        e = 64'(f[30:23]);
        m = 64'(f[22:0]);
        if (e == 255 && m != 0) return 0;
        if (e >= 130) mag = 524288;
        else if (e == 0) mag = 0;
        else begin
            s = 134 - e;
            m = m | 64'h800000;
            if (s >= 25) mag = 0;
            else mag = longint'((m + (64'd1 << (s - 1))) >> s);
            if (mag > 524288) mag = 524288;
        end
        return f[31] ? -mag : mag;
    endfunction

    function automatic longint slot_val(logic [31:0] lo, logic [31:0] hi, int slot);
        logic [31:0] r;
        r = (slot < 2) ? lo : hi;
        return (slot & 1) ? longint'($signed(r[31:16])) : longint'($signed(r[15:0]));
    endfunction

    function automatic t_pixel_out convert_pixel(logic [127:0] d);
        longint v[4];
        logic [31:0] w[4];
        logic [31:0] p;
        logic [7:0] bytes[4];
        logic [3:0] wm;
        logic [2:0] r;
        longint sum;
        int slot;
        t_pixel_out o;
        v = '{0, 0, 0, 65536};
        for (int c = 0; c < 4; c++) w[c] = d[32*c +: 32];
        p = w[0];
        bytes = '{0, 0, 0, 0};
        wm = '0;
        if (fmt <= FMT_FLOAT32) begin
            for (int c = 0; c < 4; c++) begin
                if (c == 0 || ncomp > c) begin
                    case (fmt)
                        FMT_UNORM8:  v[c] = norm_u(64'(w[c][7:0]), 255);
                        FMT_SNORM8:  v[c] = norm_s(64'($signed(w[c][7:0])), 127);
                        FMT_UNORM16: v[c] = norm_u(64'(w[c][15:0]), 65535);
                        FMT_SNORM16: v[c] = norm_s(64'($signed(w[c][15:0])), 32767);
                        FMT_UNORM32: v[c] = norm_u(64'(w[c]), 64'hffffffff);
                        FMT_SNORM32: v[c] = norm_s(64'($signed(w[c])), 64'h7fffffff);
                        default:     v[c] = flt_to_q16(w[c]);
                    endcase
                end
            end
        end else begin
            case (fmt)
                FMT_4444: begin
                    v[3] = norm_u(64'(p[3:0]), 15);
                    v[2] = norm_u(64'(p[7:4]), 15);
                    v[1] = norm_u(64'(p[11:8]), 15);
                    v[0] = norm_u(64'(p[15:12]), 15);
                end
                FMT_5551: begin
                    v[3] = p[0] ? 65536 : 0;
                    v[2] = norm_u(64'(p[5:1]), 31);
                    v[1] = norm_u(64'(p[10:6]), 31);
                    v[0] = norm_u(64'(p[15:11]), 31);
                end
                FMT_2101010: begin
                    v[0] = norm_u(64'(p[9:0]), 1023);
                    v[1] = norm_u(64'(p[19:10]), 1023);
                    v[2] = norm_u(64'(p[29:20]), 1023);
                    v[3] = norm_u(64'(p[31:30]), 3);
                end
                FMT_565: begin
                    v[2] = norm_u(64'(p[4:0]), 31);
                    v[1] = norm_u(64'(p[10:5]), 63);
                    v[0] = norm_u(64'(p[15:11]), 31);
                end
                FMT_24_8: begin
                    v[1] = norm_u(64'(p[7:0]), 255);
                    v[0] = norm_u(64'(p[31:8]), 64'hffffff);
                end
                FMT_F32_24_8: begin
                    v[1] = norm_u(64'(w[1][7:0]), 255);
                    v[0] = flt_to_q16(p);
                end
                FMT_332: begin
                    v[2] = norm_u(64'(p[1:0]), 3);
                    v[1] = norm_u(64'(p[4:2]), 7);
                    v[0] = norm_u(64'(p[7:5]), 7);
                end
                default: ;
            endcase
        end
        for (int c = 0; c < 4; c++) begin
            r = route[3*c +: 3];
            if (r[2]) begin
                slot = int'(r[1:0]);
                sum = v[c] * slot_val(scl_lo, scl_hi, slot)
                    + slot_val(bia_lo, bia_hi, slot) * 65536;
                if (sum <= 0) bytes[slot] = 0;
                else if (sum >= (64'sd1 <<< 28)) bytes[slot] = 255;
                else bytes[slot] = 8'((sum * 255) >>> 28);
                wm[slot] = 1'b1;
            end
        end
        o.b0 = bytes[0];
        o.b1 = bytes[1];
        o.b2 = bytes[2];
        o.b3 = bytes[3];
        o.wmask = wm;
        return o;
    endfunction

    assign o_pending = expected_pixels.size();

    always @(posedge i_clk) begin
        t_pixel_out got, want;
        if (!i_rst_n) begin
            fmt    <= FMT_UNORM8;
            ncomp  <= 3'd4;
            route  <= 12'd4012;
            scl_lo <= 32'h10001000;
            scl_hi <= 32'h10001000;
            bia_lo <= '0;
            bia_hi <= '0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FORMAT:   fmt    <= i_cfg_wdata[3:0];
                    CFG_COUNT:    ncomp  <= i_cfg_wdata[2:0];
                    CFG_ROUTING:  route  <= i_cfg_wdata[11:0];
                    CFG_SCALE_LO: scl_lo <= i_cfg_wdata;
                    CFG_SCALE_HI: scl_hi <= i_cfg_wdata;
                    CFG_BIAS_LO:  bia_lo <= i_cfg_wdata;
                    CFG_BIAS_HI:  bia_hi <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expected_pixels.insert(expected_pixels.size(), convert_pixel(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[35:0];
                if (expected_pixels.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected output transaction: %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: mask exp %h act %h, bytes exp %h act %h",
                                     want.wmask, got.wmask, want[31:0], got[31:0]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[bench/tb_top.sv]
module tb_top;
    import pfnsb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    int           fail_count;
    int           pending;
    int           stall_mode = 0;

    always #2 i_clk = ~i_clk;

    pixel_format_normalize_scale_bias DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    pfnsb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: stall mode changes now and then; mode 0 never stalls
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold valid until accepted; gap only between bursts
    task automatic send_pixel(logic [127:0] d, bit last_of_burst);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        if (last_of_burst) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Advance the clock before polling so the last accepted transaction is counted
    task automatic drain;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word(logic [3:0] f);
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            2: w = 32'h80000000;
            3: w = 32'h7fffffff;
            4: w = {w[31], 8'($urandom_range(110, 140)), w[22:0]};
            5: w = {w[31], 8'hff, w[22:0]};
            default: ;
        endcase
        if (f == FMT_SNORM8 && $urandom_range(0, 7) == 0) w[7:0] = 8'h80;
        if (f == FMT_SNORM16 && $urandom_range(0, 7) == 0) w[15:0] = 16'h8000;
        return w;
    endfunction

    function automatic logic [31:0] rand_slot_pair;
        logic [15:0] a, b;
        a = 16'($urandom);
        b = 16'($urandom);
        case ($urandom_range(0, 5))
            0: a = 16'h1000;
            1: a = 16'h8000;
            2: a = 16'h7fff;
            3: a = 16'($urandom_range(0, 8192));
            default: ;
        endcase
        if ($urandom_range(0, 2) == 0) b = 16'h1000;
        return {b, a};
    endfunction

    initial begin
        #2_000_000;
        $display("** pixel_format_normalize_scale_bias: FAILED **");
        $finish;
    end

    initial begin
        logic [127:0] d;
        int burst;
        logic [3:0] f;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, extremes of words
        send_pixel('0, 1'b0);
        send_pixel('1, 1'b0);
        send_pixel({4{32'h80808080}}, 1'b0);
        send_pixel({4{32'h7f7f7f7f}}, 1'b1);
        drain();
        // Every format once with a rich word and its edges, one-to-one routing
        write_reg(CFG_ROUTING, 32'(12'b111_110_101_100));
        write_reg(CFG_SCALE_LO, 32'h7fff8000);
        write_reg(CFG_BIAS_HI, 32'h00008000);
        for (int k = 0; k < 16; k++) begin
            drain();
            write_reg(CFG_FORMAT, 32'(k));
            write_reg(CFG_COUNT, 32'(1 + k % 4));
            send_pixel({32'hff800000, 32'h7f800000, 32'h7fc00001, 32'h40ffffff}, 1'b0);
            send_pixel({32'h00000001, 32'hc0ffffff, 32'h80000000, 32'hffff8000}, 1'b1);
        end
        drain();
        // Shared target byte and no routing
        write_reg(CFG_ROUTING, 32'(12'b101_101_100_100));
        send_pixel({4{32'h12345678}}, 1'b1);
        drain();
        write_reg(CFG_ROUTING, 32'd0);
        send_pixel({4{32'hdeadbeef}}, 1'b1);
        drain();

        // Random phases, config changed only while idle
        for (int ph = 0; ph < 37; ph++) begin
            f = (ph % 8 == 7) ? 4'($urandom_range(14, 15)) : 4'($urandom_range(0, 13));
            write_reg(CFG_FORMAT, 32'(f));
            write_reg(CFG_COUNT, 32'($urandom_range(0, 7)));
            write_reg(CFG_ROUTING, 32'(12'($urandom)));
            write_reg(CFG_SCALE_LO, rand_slot_pair());
            write_reg(CFG_SCALE_HI, rand_slot_pair());
            write_reg(CFG_BIAS_LO, ($urandom_range(0, 1) != 0) ? rand_slot_pair() : '0);
            write_reg(CFG_BIAS_HI, ($urandom_range(0, 1) != 0) ? rand_slot_pair() : '0);
            burst = $urandom_range(1, 12);
            for (int n = 0; n < 50; n++) begin
                d = {rand_word(f), rand_word(f), rand_word(f), rand_word(f)};
                burst--;
                send_pixel(d, burst == 0);
                if (burst == 0) burst = $urandom_range(1, 12);
            end
            s_tvalid <= 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("** pixel_format_normalize_scale_bias: PASSED **");
        else
            $display("** pixel_format_normalize_scale_bias: FAILED **");
        $finish;
    end
endmodule
